// File: design/cartridge_rtc_registers_top_assert.svh
// ----------------------------------------------------------------------------
// rtc register block assertion macros
// shared implication forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_RTC_REGISTERS_TOP_ASSERT_SVH
`define CARTRIDGE_RTC_REGISTERS_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CRTC_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtc register check failed");

// next-cycle implication, disabled in reset
`define CRTC_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtc register check failed");

`endif

// File: design/crtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc register package
// field widths, register codes, time constants and small helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crtc_pkg;

	// stream payload widths
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 5;
	localparam int OUT_TDATA_W = 8;

	// request kinds
	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	// register numbers
	localparam logic [3:0] REG_SEC    = 4'd8;
	localparam logic [3:0] REG_MIN    = 4'd9;
	localparam logic [3:0] REG_HOUR   = 4'd10;
	localparam logic [3:0] REG_DAY_LO = 4'd11;
	localparam logic [3:0] REG_DAY_HI = 4'd12;

	// seconds per unit
	localparam logic [31:0] SECS_PER_MIN   = 32'd60;
	localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
	localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
	localparam logic [31:0] SECS_PER_EPOCH = 32'd22118400;

	// reciprocals for exact floor division of 32-bit values
	localparam logic [31:0] RECIP_60       = 32'h8888_8889;
	localparam int          RECIP_60_SHIFT = 37;
	localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;
	localparam int          RECIP_3_SHIFT  = 33;

	// quotient widths
	localparam int Q60_W    = 27;
	localparam int Q3600_W  = 21;
	localparam int Q86400_W = 16;

	// byte mod 60 by restoring steps
	function automatic logic [7:0] mod60_byte(input logic [7:0] d);
		logic [7:0] r;
		r = d;
		if (r >= 8'd240) r = r - 8'd240;
		if (r >= 8'd120) r = r - 8'd120;
		if (r >= 8'd60)  r = r - 8'd60;
		return r;
	endfunction

	// byte mod 24 by restoring steps
	function automatic logic [7:0] mod24_byte(input logic [7:0] d);
		logic [7:0] r;
		r = d;
		if (r >= 8'd192) r = r - 8'd192;
		if (r >= 8'd96)  r = r - 8'd96;
		if (r >= 8'd48)  r = r - 8'd48;
		if (r >= 8'd24)  r = r - 8'd24;
		return r;
	endfunction

endpackage

// File: design/cartridge_rtc_registers_top.sv
// ----------------------------------------------------------------------------
// cartridge rtc registers
// Clock register file for an emulated cartridge. Each request carries the
// host second count; the block keeps one 32-bit offset and decodes seconds,
// minutes, hours and a 9-bit day count from now minus offset. A read of
// registers 8 to 12 returns that field, any other register reads 0, and a
// write returns 0 and moves the offset so the written field takes effect.
// Requests pass a five-register chain (input, three divide stages, output):
// reads are taken one per cycle while the output is not stalled and no write is
// in flight; a write holds s_tready low until it reaches the output register,
// so the next request enters only after that. The stall exists because the
// offset feeds back around the divide-by-60/60/24 chain. Reset clears the
// offset to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartridge_rtc_registers_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [crtc_pkg::IN_TDATA_W-1:0]  s_tdata,  // write_data, now_seconds
	input  logic [crtc_pkg::IN_TUSER_W-1:0]  s_tuser,  // action, reg_select
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [crtc_pkg::OUT_TDATA_W-1:0] m_tdata   // read_data
);
	import crtc_pkg::*;

	// stage occupancy and flow
	logic v_s1, v_s2, v_s3, v_s4;
	logic free_out, free_4, free_3, free_2, free_1;
	logic write_busy;

	// stage 1: captured request
	logic        act_s1;
	logic [3:0]  sel_s1;
	logic [7:0]  data_s1;
	logic [31:0] now_s1;

	// stage 2: elapsed low bits and minutes quotient
	logic             act_s2;
	logic [3:0]       sel_s2;
	logic [7:0]       wval_s2;
	logic [7:0]       e_lo_s2;
	logic [Q60_W-1:0] q60_s2;

	// stage 3: seconds and hours quotient
	logic               act_s3;
	logic [3:0]         sel_s3;
	logic [7:0]         wval_s3;
	logic [5:0]         sec_s3;
	logic [7:0]         q60_lo_s3;
	logic [Q3600_W-1:0] q3600_s3;

	// stage 4: minutes and days quotient
	logic                act_s4;
	logic [3:0]          sel_s4;
	logic [7:0]          wval_s4;
	logic [5:0]          sec_s4;
	logic [5:0]          min_s4;
	logic [7:0]          q3600_lo_s4;
	logic [Q86400_W-1:0] q86400_s4;

	// output and state
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic [31:0] offset_q;

	// combinational stage results
	logic [31:0] elapsed;
	logic [63:0] prod60_a, prod60_b, prod3;
	logic [7:0]  wval_c;
	logic [7:0]  sec_full, min_full, hr_full;
	logic [4:0]  hr_c;
	logic [7:0]  epoch_c;
	logic [7:0]  rd_c;
	logic [31:0] delta_c;

	// flow control: a stage takes the next item when empty or draining
	assign free_out   = !m_tvalid_q || m_tready;
	assign free_4     = !v_s4 || free_out;
	assign free_3     = !v_s3 || free_4;
	assign free_2     = !v_s2 || free_3;
	assign free_1     = !v_s1 || free_2;
	assign write_busy = (v_s1 && act_s1 == ACT_WRITE) || (v_s2 && act_s2 == ACT_WRITE)
		|| (v_s3 && act_s3 == ACT_WRITE) || (v_s4 && act_s4 == ACT_WRITE);
	assign s_tready   = free_1 && !write_busy;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// elapsed time, first quotient and write value reduction
	always_comb begin
		elapsed  = now_s1 - offset_q;
		prod60_a = 64'(elapsed) * 64'(RECIP_60);
		case (sel_s1)
			REG_SEC, REG_MIN: wval_c = mod60_byte(data_s1);
			REG_HOUR:         wval_c = mod24_byte(data_s1);
			REG_DAY_HI:       wval_c = {7'd0, data_s1[0]};
			default:          wval_c = data_s1;
		endcase
	end

	// hours quotient and seconds remainder
	always_comb begin
		prod60_b = 64'(q60_s2) * 64'(RECIP_60);
		sec_full = e_lo_s2 - 8'(q60_s2[7:0] * 8'd60);
	end

	// days quotient and minutes remainder
	always_comb begin
		prod3    = 64'(q3600_s3[Q3600_W-1:3]) * 64'(RECIP_3);
		min_full = q60_lo_s3 - 8'(q3600_s3[7:0] * 8'd60);
	end

	// hours remainder, read select and offset correction
	always_comb begin
		hr_full = q3600_lo_s4 - 8'(q86400_s4[7:0] * 8'd24);
		hr_c    = hr_full[4:0];
		epoch_c = q86400_s4[15:8];
		case (sel_s4)
			REG_SEC:    rd_c = {2'd0, sec_s4};
			REG_MIN:    rd_c = {2'd0, min_s4};
			REG_HOUR:   rd_c = {3'd0, hr_c};
			REG_DAY_LO: rd_c = q86400_s4[7:0];
			REG_DAY_HI: rd_c = {7'd0, q86400_s4[8]};
			default:    rd_c = 8'd0;
		endcase
		// offset moves by old field minus new field, in seconds
		case (sel_s4)
			REG_SEC:    delta_c = 32'(sec_s4) - 32'(wval_s4);
			REG_MIN:    delta_c = 32'(min_s4) * SECS_PER_MIN - 32'(wval_s4) * SECS_PER_MIN;
			REG_HOUR:   delta_c = 32'(hr_c) * SECS_PER_HOUR - 32'(wval_s4) * SECS_PER_HOUR;
			REG_DAY_LO: delta_c = 32'(q86400_s4[7:0]) * SECS_PER_DAY
				- 32'(wval_s4) * SECS_PER_DAY;
			REG_DAY_HI: delta_c = 32'(epoch_c) * SECS_PER_EPOCH
				- 32'(wval_s4) * SECS_PER_EPOCH;
			default:    delta_c = 32'd0;
		endcase
	end

	// valid bits, output valid and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
			offset_q   <= 32'd0;
		end else begin
			if (free_1) v_s1 <= s_tvalid && !write_busy;
			if (free_2) v_s2 <= v_s1;
			if (free_3) v_s3 <= v_s2;
			if (free_4) v_s4 <= v_s3;
			if (free_out) begin
				m_tvalid_q <= v_s4;
				if (v_s4 && act_s4 == ACT_WRITE) offset_q <= offset_q + delta_c;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (free_1) begin
			act_s1  <= s_tuser[0];
			sel_s1  <= s_tuser[4:1];
			data_s1 <= s_tdata[7:0];
			now_s1  <= s_tdata[39:8];
		end
		if (free_2) begin
			act_s2  <= act_s1;
			sel_s2  <= sel_s1;
			wval_s2 <= wval_c;
			e_lo_s2 <= elapsed[7:0];
			q60_s2  <= prod60_a[RECIP_60_SHIFT +: Q60_W];
		end
		if (free_3) begin
			act_s3    <= act_s2;
			sel_s3    <= sel_s2;
			wval_s3   <= wval_s2;
			sec_s3    <= sec_full[5:0];
			q60_lo_s3 <= q60_s2[7:0];
			q3600_s3  <= prod60_b[RECIP_60_SHIFT +: Q3600_W];
		end
		if (free_4) begin
			act_s4      <= act_s3;
			sel_s4      <= sel_s3;
			wval_s4     <= wval_s3;
			sec_s4      <= sec_s3;
			min_s4      <= min_full[5:0];
			q3600_lo_s4 <= q3600_s3[7:0];
			q86400_s4   <= prod3[RECIP_3_SHIFT +: Q86400_W];
		end
		if (free_out) begin
			m_tdata_q <= (act_s4 == ACT_WRITE) ? 8'd0 : rd_c;
		end
	end

endmodule

// File: design/crtc_checker.sv
// ----------------------------------------------------------------------------
// rtc register port checker
// watches the stream ports for occupancy and write ordering
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cartridge_rtc_registers_top_assert.svh"

module crtc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [crtc_pkg::IN_TUSER_W-1:0]  s_tuser,  // action, reg_select
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [crtc_pkg::OUT_TDATA_W-1:0] m_tdata   // read_data
);
	import crtc_pkg::*;

	// requests accepted but not yet delivered
	logic [2:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// pending request count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	// stalled result holds
	`CRTC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// no more requests in flight than the chain holds
	`CRTC_ASSERT_IMP(a_pending_max, 1'b1, pending_q <= 3'd5)
	// a result only for an accepted request
	`CRTC_ASSERT_IMP(a_no_phantom, m_tvalid, pending_q != 3'd0)
	// a write blocks the next request while it updates the offset
	`CRTC_ASSERT_NXT(a_write_blocks, in_acc && s_tuser[0] == ACT_WRITE, !s_tready)

endmodule

bind cartridge_rtc_registers_top crtc_checker u_crtc_checker (.*);
